// ===== design/rwpg_pkg.sv =====
// Shared types, constants and sine table builder for the rainbow wave generator.
// No dependencies.
`default_nettype none

package rwpg_pkg;

    localparam int SINE_N  = 1024;
    localparam int SINE_AW = $clog2(SINE_N);

    localparam logic [SINE_AW:0] SINE_N_V    = (SINE_AW + 1)'(SINE_N);
    localparam logic [SINE_AW:0] SINE_LAST_V = (SINE_AW + 1)'(SINE_N - 1);

    localparam logic [22:0] RAD_TO_TURN_Q16 = 23'd5340354;
    localparam logic [7:0]  PHASE_INC_RESET = 8'd4;
    localparam logic [5:0]  PIX_LAST        = 6'd63;
    localparam logic [2:0]  ROW_LAST        = 3'd7;
    localparam logic [2:0]  COL_LAST        = 3'd7;

    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598670;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026996;
    localparam logic [63:0] SC9 = 64'd172272;

    typedef logic signed [15:0] sine_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] phase;
        logic       last;
    } pix_tag_t;

    // sin(pi/2 * z), z in Q14; result Q14, evaluated at elaboration only
    function automatic logic [14:0] quarter_sine(input logic [14:0] z14);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] r;
        z  = 64'(z14) << 16;
        z2 = (z * z) >> 30;
        p  = SC9;
        p  = SC7 - ((z2 * p) >> 30);
        p  = SC5 - ((z2 * p) >> 30);
        p  = SC3 - ((z2 * p) >> 30);
        p  = SC1 - ((z2 * p) >> 30);
        r  = (z * p) >> 30;
        r  = (r + 64'd32768) >> 16;
        if (r > 64'd16384)
            r = 64'd16384;
        return r[14:0];
    endfunction

    function automatic sine_t sine_value(input int unsigned i);
        logic [31:0] t;
        logic [14:0] z;
        logic [14:0] qs;
        sine_t       res;
        t = 32'((64'(i) << 16) / SINE_N);
        case (t[15:14])
            2'd0, 2'd2: z = {1'b0, t[13:0]};
            default:    z = 15'd16384 - {1'b0, t[13:0]};
        endcase
        qs = quarter_sine(z);
        if (t[15])
            res = -$signed({1'b0, qs});
        else
            res = $signed({1'b0, qs});
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/rwpg_if.sv =====
// Handshake channel interfaces: frame request, configuration write, pixel output.
// No dependencies.
`default_nettype none

interface rwpg_req_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink (input valid, input advance, output ready);
endinterface

interface rwpg_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] phase_increment;

    modport source (output valid, output phase_increment, input ready);
    modport sink (input valid, input phase_increment, output ready);
endinterface

interface rwpg_pix_if;
    logic       valid;
    logic       ready;
    logic [2:0] pixel_row;
    logic [2:0] pixel_col;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, output pixel_row, output pixel_col, output red,
                    output green, output blue, output frame_end, input ready);
    modport sink (input valid, input pixel_row, input pixel_col, input red,
                  input green, input blue, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== design/rwpg_sine_rom.sv =====
// Synchronous sine ROM, Q14 values over one turn, registered read.
// Depends on rwpg_pkg.
`default_nettype none

module rwpg_sine_rom (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [rwpg_pkg::SINE_AW-1:0]  addr,
    output rwpg_pkg::sine_t                    rd_data
);
    import rwpg_pkg::*;

    sine_t rom [SINE_N];

    for (genvar i = 0; i < SINE_N; i++) begin : g_rom
        assign rom[i] = sine_value(i);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data <= rom[addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/rwpg_scan.sv =====
// Frame sequencer: phase register, config register, pixel counter, ROM address.
// Depends on rwpg_pkg and rwpg_if.
`default_nettype none

module rwpg_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rwpg_req_if.sink                           req,
    rwpg_cfg_if.sink                           cfg,
    input  wire logic                          adv,
    output logic [rwpg_pkg::SINE_AW-1:0]       rom_addr,
    output rwpg_pkg::pix_tag_t                 tag
);
    import rwpg_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [7:0]  phase_reg;
    logic [7:0]  phase_next;
    logic [15:0] ang_off_reg;
    logic [15:0] ang_off_next;
    logic [7:0]  inc_reg;
    logic [31:0] off_prod;
    logic        issue;
    logic        last_issue;
    logic        accept;
    logic [15:0] ang;
    logic [16+SINE_AW:0] idx_prod;
    logic [SINE_AW:0]    idx_full;

    assign issue      = busy_reg && adv;
    assign last_issue = (cnt_reg == PIX_LAST);
    assign req.ready  = adv && (!busy_reg || last_issue);
    assign accept     = req.valid && req.ready;
    assign cfg.ready  = 1'b1;

    assign phase_next   = req.advance ? (phase_reg + inc_reg) : phase_reg;
    assign off_prod     = 32'(phase_next * RAD_TO_TURN_Q16) + 32'd32768;
    assign ang_off_next = off_prod[31:16];

    assign ang      = {cnt_reg[2:0], 13'd0} + {cnt_reg[2:0], 13'd0} + ang_off_reg;
    assign idx_prod = ang * SINE_N_V;
    assign idx_full = idx_prod[16 +: SINE_AW + 1];
    assign rom_addr = (idx_full > SINE_LAST_V) ? SINE_LAST_V[SINE_AW-1:0]
                                                : idx_full[SINE_AW-1:0];

    assign tag.valid = issue;
    assign tag.row   = cnt_reg[5:3];
    assign tag.col   = cnt_reg[2:0];
    assign tag.phase = phase_reg;
    assign tag.last  = last_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            phase_reg   <= '0;
            ang_off_reg <= '0;
            inc_reg     <= PHASE_INC_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                inc_reg <= cfg.phase_increment;
            end
            if (issue)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (last_issue)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                phase_reg   <= phase_next;
                ang_off_reg <= ang_off_next;
            end
        end
    end

    a_accept_at_frame_edge: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (!busy_reg || last_issue))
        else $error("request taken mid-frame");

    a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !adv) |=> $stable(cnt_reg))
        else $error("pixel counter moved during stall");

endmodule

`default_nettype wire

// ===== design/rwpg_color.sv =====
// Pixel pipeline: hue position, sector/fraction, RGB ramps and output register.
// Depends on rwpg_pkg and rwpg_if.
`default_nettype none

module rwpg_color (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rwpg_pkg::pix_tag_t  tag,
    input  wire rwpg_pkg::sine_t     sine,
    output logic                     adv,
    rwpg_pix_if.source               pix
);
    import rwpg_pkg::*;

    localparam logic [2:0] SEC_RED_GREEN  = 3'd0;
    localparam logic [2:0] SEC_GREEN_RED  = 3'd1;
    localparam logic [2:0] SEC_GREEN_BLUE = 3'd2;
    localparam logic [2:0] SEC_BLUE_GREEN = 3'd3;
    localparam logic [2:0] SEC_BLUE_RED   = 3'd4;
    localparam logic [2:0] SEC_RED_BLUE   = 3'd5;

    typedef struct packed {
        logic        valid;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
        logic [2:0]  sector;
        logic [15:0] frac;
    } hue_t;

    pix_tag_t    s1_reg;
    hue_t        s2_reg;
    hue_t        s2_next;
    logic [15:0] pos;
    logic [18:0] x6;
    logic [23:0] rise_prod;
    logic [23:0] fall_prod;
    logic [7:0]  rise;
    logic [7:0]  fall;
    logic [7:0]  red_next;
    logic [7:0]  green_next;
    logic [7:0]  blue_next;

    logic        out_valid_reg;
    logic [2:0]  row_reg;
    logic [2:0]  col_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        frame_end_reg;

    assign adv = !out_valid_reg || pix.ready;

    // position wraps mod 1 turn, so phase*512 keeps only the low 7 phase bits
    assign pos = {s1_reg.row, 13'd0} + $unsigned(sine) + {s1_reg.phase[6:0], 9'd0};
    assign x6  = ({3'd0, pos} << 2) + ({3'd0, pos} << 1);

    assign s2_next.valid  = s1_reg.valid;
    assign s2_next.row    = s1_reg.row;
    assign s2_next.col    = s1_reg.col;
    assign s2_next.last   = s1_reg.last;
    assign s2_next.sector = x6[18:16];
    assign s2_next.frac   = x6[15:0];

    assign rise_prod = 24'(s2_reg.frac * 8'd255);
    assign fall_prod = 24'((17'h10000 - {1'b0, s2_reg.frac}) * 8'd255);
    assign rise      = rise_prod[23:16];
    assign fall      = fall_prod[23:16];

    always_comb
    begin
        case (s2_reg.sector)
            SEC_RED_GREEN:  begin red_next = 8'd255; green_next = rise;   blue_next = 8'd0;   end
            SEC_GREEN_RED:  begin red_next = fall;   green_next = 8'd255; blue_next = 8'd0;   end
            SEC_GREEN_BLUE: begin red_next = 8'd0;   green_next = 8'd255; blue_next = rise;   end
            SEC_BLUE_GREEN: begin red_next = 8'd0;   green_next = fall;   blue_next = 8'd255; end
            SEC_BLUE_RED:   begin red_next = rise;   green_next = 8'd0;   blue_next = 8'd255; end
            default:        begin red_next = 8'd255; green_next = 8'd0;   blue_next = fall;   end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_reg        <= tag;
            s2_reg        <= s2_next;
            out_valid_reg <= s2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_reg       <= s2_reg.row;
            col_reg       <= s2_reg.col;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            frame_end_reg <= s2_reg.last;
        end
    end

    assign pix.valid     = out_valid_reg;
    assign pix.pixel_row = row_reg;
    assign pix.pixel_col = col_reg;
    assign pix.red       = red_reg;
    assign pix.green     = green_reg;
    assign pix.blue      = blue_reg;
    assign pix.frame_end = frame_end_reg;

    a_frame_end_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frame_end_reg == ((row_reg == ROW_LAST) && (col_reg == COL_LAST))))
        else $error("frame_end not on last pixel");

    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_reg.valid |-> (s2_reg.sector <= SEC_RED_BLUE))
        else $error("hue sector out of range");

endmodule

`default_nettype wire

// ===== design/rainbow_wave_pixel_generator.sv =====
// Rainbow wave pixel generator for an 8x8 LED matrix, top level.
// Depends on rwpg_pkg, rwpg_if, rwpg_sine_rom, rwpg_scan, rwpg_color.
//
// Channels:
//   req   - one item per frame; advance=1 moves the phase by phase_increment first.
//   cfg   - write of phase_increment (reset 4); always ready, write while idle.
//   pixel - 64 items per frame, row-major from (0,0); frame_end marks (7,7).
// Throughput: one pixel per cycle while the receiver does not stall; the pixel
// counter paces the block, and the next request is taken in the cycle the
// 64th pixel of the current frame is issued, so frames run back to back.
// A pixel passes through issue and sine ROM read, the hue stage, and the color
// stage into the output register.
// Reset clears phase to 0 and empties the pipeline; the sine ROM is constant
// and needs no initialization pass.
// Receiver stall: when pixel.ready is low with a pixel waiting, the whole
// pipeline and the ROM read hold, and no new request is taken.
`default_nettype none

module rainbow_wave_pixel_generator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rwpg_req_if.sink    req,
    rwpg_cfg_if.sink    cfg,
    rwpg_pix_if.source  pixel
);
    import rwpg_pkg::*;

    logic               adv;
    logic [SINE_AW-1:0] rom_addr;
    pix_tag_t           tag;
    sine_t              sine;

    rwpg_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg      (cfg),
        .adv      (adv),
        .rom_addr (rom_addr),
        .tag      (tag)
    );

    rwpg_sine_rom u_rom (
        .clk     (clk),
        .en      (adv),
        .addr    (rom_addr),
        .rd_data (sine)
    );

    rwpg_color u_color (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag),
        .sine  (sine),
        .adv   (adv),
        .pix   (pixel)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rainbow_wave_pixel_generator. It predicts all 64 pixels of
// each frame request and checks them in order under random idling on both channels.
// Depends on rwpg_pkg, rwpg_if and the design sources.

module testbench;
    import rwpg_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        HUE_RED_GREEN_UP,
        HUE_GREEN_RED_DOWN,
        HUE_GREEN_BLUE_UP,
        HUE_BLUE_GREEN_DOWN,
        HUE_BLUE_RED_UP,
        HUE_RED_BLUE_DOWN
    } hue_sector_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_t;

    logic clk;
    logic rst_n;

    rwpg_req_if req_ch ();
    rwpg_cfg_if cfg_ch ();
    rwpg_pix_if pix_ch ();

    rainbow_wave_pixel_generator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .pixel (pix_ch)
    );

    int         sine_q14 [SINE_N];
    pixel_t     expected_pixels [$];
    logic [7:0] cur_phase;
    logic [7:0] cur_increment;
    bit         src_steady;
    bit         snk_steady;
    int         mismatches = 0;
    int         cycles = 0;

    // sin(pi/2 * z), z in Q14, result in Q14
    function automatic int quarter_wave(input int unsigned z14);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] r;
        z  = 64'(z14) << 16;
        z2 = (z * z) >> 30;
        p  = SC9;
        p  = SC7 - ((z2 * p) >> 30);
        p  = SC5 - ((z2 * p) >> 30);
        p  = SC3 - ((z2 * p) >> 30);
        p  = SC1 - ((z2 * p) >> 30);
        r  = (z * p) >> 30;
        r  = (r + 64'd32768) >> 16;
        if (r > 64'd16384)
            r = 64'd16384;
        return int'(r);
    endfunction

    function automatic int wheel_sine(input logic [15:0] t);
        case (t[15:14])
            2'd0:    return quarter_wave(t[13:0]);
            2'd1:    return quarter_wave(16384 - t[13:0]);
            2'd2:    return -quarter_wave(t[13:0]);
            default: return -quarter_wave(16384 - t[13:0]);
        endcase
    endfunction

    function automatic pixel_t render_pixel(input logic [2:0] row, input logic [2:0] col,
                                            input logic [7:0] ph);
        logic [63:0] turn;
        logic [15:0] ang;
        int unsigned idx;
        int          sum;
        logic [15:0] pos;
        logic [31:0] x;
        logic [15:0] frac;
        logic [7:0]  rise;
        logic [7:0]  fall;
        pixel_t      px;
        turn = (64'(ph) * 64'(RAD_TO_TURN_Q16) + 64'd32768) >> 16;
        ang  = 16'((64'(col) << 14) + turn);
        idx  = int'((64'(ang) * 64'(SINE_N)) >> 16);
        if (idx >= SINE_N)
            idx = SINE_N - 1;
        sum  = int'(row) * 8192 + sine_q14[idx] + int'(ph) * 512;
        pos  = sum[15:0];
        x    = 32'(pos) * 32'd6;
        frac = x[15:0];
        rise = 8'((32'(frac) * 32'd255) >> 16);
        fall = 8'(((32'd65536 - 32'(frac)) * 32'd255) >> 16);
        px.row       = row;
        px.col       = col;
        px.frame_end = (row == ROW_LAST) && (col == COL_LAST);
        case (hue_sector_t'(x[18:16]))
            HUE_RED_GREEN_UP:    {px.red, px.green, px.blue} = {8'd255, rise, 8'd0};
            HUE_GREEN_RED_DOWN:  {px.red, px.green, px.blue} = {fall, 8'd255, 8'd0};
            HUE_GREEN_BLUE_UP:   {px.red, px.green, px.blue} = {8'd0, 8'd255, rise};
            HUE_BLUE_GREEN_DOWN: {px.red, px.green, px.blue} = {8'd0, fall, 8'd255};
            HUE_BLUE_RED_UP:     {px.red, px.green, px.blue} = {rise, 8'd0, 8'd255};
            default:             {px.red, px.green, px.blue} = {8'd255, 8'd0, fall};
        endcase
        return px;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_idle(input bit steady);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic predict_frame(input logic adv);
        if (adv)
            cur_phase = cur_phase + cur_increment;
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                expected_pixels.push_back(render_pixel(3'(r), 3'(c), cur_phase));
    endtask

    task automatic send_frame(input logic adv);
        int gap;
        gap = pick_idle(src_steady);
        if (gap > 0)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.advance <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.advance <= adv;
        do @(posedge clk); while (!req_ch.ready);
        predict_frame(adv);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_increment(input logic [7:0] value);
        wait_drained();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.phase_increment <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid           <= 1'b0;
        cfg_ch.phase_increment <= 8'($urandom);
        cur_increment = value;
    endtask

    task automatic test_reset_state();
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    // 255 makes the phase wrap on every advance
    task automatic test_increment_extremes();
        write_increment(8'd255);
        send_frame(1'b1);
        send_frame(1'b1);
        send_frame(1'b1);
        write_increment(8'd0);
        send_frame(1'b1);
        send_frame(1'b0);
        write_increment(8'd128);
        send_frame(1'b1);
        send_frame(1'b1);
        write_increment(8'd1);
        send_frame(1'b1);
    endtask

    task automatic test_back_to_back();
        src_steady = 1'b1;
        snk_steady = 1'b1;
        write_increment(8'h55);
        send_frame(1'b1);
        send_frame(1'b1);
        send_frame(1'b1);
        write_increment(8'hAA);
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_frame(1'b1);
        send_frame(1'b1);
        send_frame(1'b1);
        wait_drained();
        send_frame(1'b0);
        send_frame(1'b1);
    endtask

    task automatic test_random_frames();
        logic [7:0] inc;
        for (int round = 0; round < 5; round++)
        begin
            case ($urandom_range(0, 4))
                0:       inc = 8'd0;
                1:       inc = 8'd255;
                default: inc = 8'($urandom_range(0, 255));
            endcase
            write_increment(inc);
            src_steady = ($urandom_range(0, 3) == 0);
            snk_steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 50; n++)
                send_frame(1'($urandom_range(0, 3) != 0));
        end
        src_steady = 1'b0;
        snk_steady = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        int run;
        int gap;
        pix_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            pix_ch.ready <= 1'b1;
            run = $urandom_range(1, 16);
            repeat (run) @(posedge clk);
            gap = pick_idle(snk_steady);
            if (gap > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = {pix_ch.pixel_row, pix_ch.pixel_col, pix_ch.red, pix_ch.green,
                   pix_ch.blue, pix_ch.frame_end};
            if (expected_pixels.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected pixel r%0d c%0d rgb %0d,%0d,%0d end %0d",
                             got.row, got.col, got.red, got.green, got.blue, got.frame_end);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("pixel mismatch: expected r%0d c%0d rgb %0d,%0d,%0d end %0d",
                                 want.row, want.col, want.red, want.green, want.blue,
                                 want.frame_end);
                        $display("                got      r%0d c%0d rgb %0d,%0d,%0d end %0d",
                                 got.row, got.col, got.red, got.green, got.blue,
                                 got.frame_end);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < SINE_N; i++)
            sine_q14[i] = wheel_sine(16'((64'(i) << 16) / SINE_N));
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.advance         <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.phase_increment <= 8'd0;
        cur_phase     = 8'd0;
        cur_increment = PHASE_INC_RESET;
        src_steady    = 1'b0;
        snk_steady    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_increment_extremes();
        test_back_to_back();
        test_drain_pause();
        test_random_frames();
        wait_drained();
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
